>>> rtl/dsd_pkg.sv
// Shared types and constants for the dedup set with sorted dump.
package dsd_pkg;

  localparam int AREA_W       = 16;
  localparam int NUM_W        = 32;
  localparam int COUNT_W      = 7;
  localparam int DEF_CAPACITY = 64;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [AREA_W-1:0] area;
    logic [NUM_W-1:0]  num;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp;  // register hit / key-less-than flags
    logic ins;  // sorted insert of the key
    logic rot;  // rotate occupied cells one place toward cell 0
  } cell_ctl_t;

endpackage

>>> rtl/dsd_cell.sv
// One storage cell of the sorted chain: holds one entry, compares, shifts.
module dsd_cell
  import dsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic [AREA_W-1:0] key_area,
  input  logic [NUM_W-1:0]  key_num,
  input  entry_t            prev_ent,
  input  logic              prev_lt,
  input  entry_t            next_ent,
  input  entry_t            head_ent,
  output entry_t            ent,
  output logic              lt,
  output logic              hit
);

  logic tail;

  // last occupied cell of the chain
  assign tail = ent.valid && !next_ent.valid;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      hit <= ent.valid && (ent.area == key_area) && (ent.num == key_num);
      lt  <= !ent.valid || ({key_area, key_num} < {ent.area, ent.num});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (ctl.ins) begin
      if (prev_lt) begin
        ent <= prev_ent;
      end else if (lt) begin
        ent <= '{valid: 1'b1, area: key_area, num: key_num};
      end
    end else if (ctl.rot) begin
      if (tail) begin
        ent <= head_ent;
      end else if (ent.valid) begin
        ent <= next_ent;
      end
    end
  end

endmodule

>>> rtl/dedup_set_with_sorted_dump_unit.sv
// Top level: deduplicating pair set built as a sorted chain of cells.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | into unit | in_valid / in_stall    | cmd, area, msg_num
//  out     | from unit | out_valid / out_stall  | accepted, was_present, entry_area,
//          |           |                        | entry_num, entry_count, list_empty, last
//
// Insert and lookup step through accept, compare in every cell, and result.
// A dump emits cell 0 each cycle that the output is not stalled while the
// occupied cells rotate, so the chain is back in place after the last transfer.
// The chain is kept sorted at all times, so a dump needs no extra sort pass.
// Reset clears the cell valid bits and the fill count at once; no clearing pass.
// An output stall holds the unit in its result or dump step; in_stall is low
// only while the unit is idle, so one item is in work at a time.
module dedup_set_with_sorted_dump_unit
  import dsd_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [AREA_W-1:0]  area,
  input  logic [NUM_W-1:0]   msg_num,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               accepted,
  output logic               was_present,
  output logic [AREA_W-1:0]  entry_area,
  output logic [NUM_W-1:0]   entry_num,
  output logic [COUNT_W-1:0] entry_count,
  output logic               list_empty,
  output logic               last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_RES  = 4'b0100,
    S_DUMP = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [1:0]        cmd_q;
  logic [AREA_W-1:0] key_area;
  logic [NUM_W-1:0]  key_num;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [CNT_W-1:0]  dump_left, dump_left_next;

  cell_ctl_t         ctl;
  entry_t            ent [CAPACITY];
  logic [CAPACITY-1:0] lt_vec, hit_vec, vld_vec;

  // result being loaded into the output register
  logic               res_load;
  logic               res_acc, res_pres, res_empty, res_last;
  logic [AREA_W-1:0]  res_area;
  logic [NUM_W-1:0]   res_num;
  logic [CNT_W-1:0]   res_cnt;
  logic               out_free, present, room;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign present  = |hit_vec;
  assign room     = (cnt < CNT_W'(CAPACITY));

  // ---------------------------------------------------------------------------
  // Cell chain: cell i sees cell i-1 (insert shift) and cell i+1 (rotate).
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t pe, ne;
    logic   pl;

    if (i == 0) begin : g_first
      assign pe = '0;
      assign pl = 1'b0;
    end else begin : g_mid
      assign pe = ent[i-1];
      assign pl = lt_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign ne = '0;
    end else begin : g_body
      assign ne = ent[i+1];
    end

    dsd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .key_area (key_area),
      .key_num  (key_num),
      .prev_ent (pe),
      .prev_lt  (pl),
      .next_ent (ne),
      .head_ent (ent[0]),
      .ent      (ent[i]),
      .lt       (lt_vec[i]),
      .hit      (hit_vec[i])
    );

    assign vld_vec[i] = ent[i].valid;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    dump_left_next = dump_left;
    ctl            = '0;
    res_load       = 1'b0;
    res_acc        = 1'b0;
    res_pres       = 1'b0;
    res_empty      = 1'b0;
    res_last       = 1'b1;
    res_area       = '0;
    res_num        = '0;
    res_cnt        = cnt;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        ctl.cmp    = 1'b1;
        state_next = S_RES;
      end
      S_RES: begin
        if (out_free) begin
          state_next = S_IDLE;
          case (cmd_q)
            CMD_INSERT: begin
              res_load = 1'b1;
              res_pres = present;
              res_acc  = present || room;
              if (!present && room) begin
                ctl.ins  = 1'b1;
                cnt_next = cnt + 1'b1;
                res_cnt  = cnt + 1'b1;
              end
            end
            CMD_LOOKUP: begin
              res_load = 1'b1;
              res_pres = present;
            end
            CMD_DUMP: begin
              if (cnt == '0) begin
                res_load  = 1'b1;
                res_empty = 1'b1;
              end else begin
                dump_left_next = cnt;
                state_next     = S_DUMP;
              end
            end
            default: begin
              // unknown command: bare acknowledge
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ctl.rot        = 1'b1;
          res_load       = 1'b1;
          res_area       = ent[0].area;
          res_num        = ent[0].num;
          res_last       = (dump_left == CNT_W'(1));
          dump_left_next = dump_left - 1'b1;
          if (res_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    dump_left <= dump_left_next;
    if (state == S_IDLE && in_valid) begin
      cmd_q    <= cmd;
      key_area <= area;
      key_num  <= msg_num;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      accepted    <= res_acc;
      was_present <= res_pres;
      entry_area  <= res_area;
      entry_num   <= res_num;
      entry_count <= COUNT_W'(res_cnt);
      list_empty  <= res_empty;
      last        <= res_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_cnt_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(vld_vec) == int'(cnt))
    else $error("occupied cells disagree with fill count");

  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    ((vld_vec + 1'b1) & vld_vec) == '0)
    else $error("occupied cells not packed toward cell 0");

  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |-> room && !present)
    else $error("insert into full chain or of a stored pair");

  a_dump_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> dump_left != '0)
    else $error("dump step with nothing left");

endmodule
